// File: rtl/core/mcld_pkg.sv
package mcld_pkg;

  // Kinds of work that the front hands to the back.
  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_CHAR,
    KIND_EOL,
    KIND_TICK
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
  } cmd_t;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_UP       = 4'd1,
    EV_DOWN     = 4'd2,
    EV_STOP     = 4'd3,
    EV_HELP     = 4'd4,
    EV_PRESENT  = 4'd5,
    EV_INVALID  = 4'd6,
    EV_OVERFLOW = 4'd7,
    EV_TIMEOUT  = 4'd8
  } event_e;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // Longest command word is "present".
  localparam int unsigned WORD_MAX = 7;
  localparam int unsigned WLEN_W   = $clog2(WORD_MAX + 1);

  typedef logic [WORD_MAX-1:0][7:0] word_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PULSE_W    = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_REVERSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STOP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FORWARD = 2'd3;

  localparam logic [CFG_DATA_W-1:0] IDLE_TIMEOUT_RST  = 32'd10000;
  localparam logic [PULSE_W-1:0]    PULSE_REVERSE_RST = 12'd1000;
  localparam logic [PULSE_W-1:0]    PULSE_STOP_RST    = 12'd1500;
  localparam logic [PULSE_W-1:0]    PULSE_FORWARD_RST = 12'd2000;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Matches a trimmed, lower-case word of n characters against the commands.
  function automatic event_e match_word(word_t w, logic [WLEN_W-1:0] n);
    event_e ev;
    ev = EV_INVALID;
    if ((n == 3'd1 && w[0] == "w") || (n == 3'd2 && w[0] == "u" && w[1] == "p")) begin
      ev = EV_UP;
    end else if ((n == 3'd1 && w[0] == "x") ||
                 (n == 3'd4 && w[0] == "d" && w[1] == "o" && w[2] == "w" &&
                  w[3] == "n")) begin
      ev = EV_DOWN;
    end else if ((n == 3'd1 && w[0] == "s") ||
                 (n == 3'd4 && w[0] == "s" && w[1] == "t" && w[2] == "o" &&
                  w[3] == "p")) begin
      ev = EV_STOP;
    end else if ((n == 3'd1 && w[0] == "h") ||
                 (n == 3'd4 && w[0] == "h" && w[1] == "e" && w[2] == "l" &&
                  w[3] == "p")) begin
      ev = EV_HELP;
    end else if ((n == 3'd1 && w[0] == "p") ||
                 (n == 3'd7 && w[0] == "p" && w[1] == "r" && w[2] == "e" &&
                  w[3] == "s" && w[4] == "e" && w[5] == "n" && w[6] == "t")) begin
      ev = EV_PRESENT;
    end
    return ev;
  endfunction

endpackage

// File: rtl/core/mcld_queue.sv
module mcld_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcld_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output mcld_pkg::cmd_t  cmd_o,
  output mcld_pkg::qstat_t stat_o
);
  import mcld_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

// File: rtl/core/mcld_front.sv
module mcld_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [7:0]       rx_byte_i,
  input  mcld_pkg::qstat_t qstat_i,
  output logic             push_o,
  output mcld_pkg::cmd_t   cmd_o
);
  import mcld_pkg::*;

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  // Characters are folded to lower case here, so the line store only ever
  // holds what the matcher compares.
  always_comb begin
    cmd_o.chr  = rx_byte_i;
    cmd_o.kind = KIND_IGNORE;
    if (func_i) begin
      cmd_o.kind = KIND_TICK;
    end else if (rx_byte_i == CHAR_LF || rx_byte_i == CHAR_CR) begin
      cmd_o.kind = KIND_EOL;
    end else if (rx_byte_i >= CHAR_SPACE && rx_byte_i <= CHAR_TILDE) begin
      cmd_o.kind = KIND_CHAR;
      if (rx_byte_i >= CHAR_UP_A && rx_byte_i <= CHAR_UP_Z) begin
        cmd_o.chr = rx_byte_i | CASE_BIT;
      end
    end
  end

endmodule

// File: rtl/core/mcld_back.sv
module mcld_back #(
  parameter int unsigned LINE_CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mcld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                q_valid_i,
  input  mcld_pkg::cmd_t                      q_cmd_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [3:0]                          event_res_o,
  output logic [mcld_pkg::PULSE_W-1:0]        pulse_us_o
);
  import mcld_pkg::*;

  localparam int unsigned DEPTH = LINE_CAPACITY - 1;
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(DEPTH);
  localparam logic [WLEN_W-1:0] WLEN_MAX = WLEN_W'(WORD_MAX);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  logic [7:0] store_q [DEPTH];
  logic [7:0] rdata_q;

  state_e                state_q, state_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [LEN_W-1:0]      idx_q, idx_d;
  logic                  rvld_q, rvld_d;
  word_t                 word_q, word_d;
  logic [WLEN_W-1:0]     wlen_q, wlen_d;
  logic                  started_q, started_d;
  logic                  gap_q, gap_d;
  logic                  bad_q, bad_d;
  logic [CFG_DATA_W-1:0] idle_q, idle_d;
  logic [PULSE_W-1:0]    pulse_q, pulse_d;
  logic [CFG_DATA_W-1:0] timeout_q, timeout_d;
  logic [PULSE_W-1:0]    rev_q, rev_d;
  logic [PULSE_W-1:0]    stop_q, stop_d;
  logic [PULSE_W-1:0]    fwd_q, fwd_d;
  logic                  out_vld_q, out_vld_d;
  event_e                out_ev_q, out_ev_d;
  logic [PULSE_W-1:0]    out_pulse_q, out_pulse_d;

  logic                  slot_free;
  logic                  mem_we;
  logic                  fetch;
  logic                  emit;
  event_e                ev;
  logic [CFG_DATA_W-1:0] idle_inc;

  assign slot_free = !out_vld_q || out_ready_i;
  assign idle_inc  = (&idle_q) ? idle_q : idle_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    rvld_d      = 1'b0;
    word_d      = word_q;
    wlen_d      = wlen_q;
    started_d   = started_q;
    gap_d       = gap_q;
    bad_d       = bad_q;
    idle_d      = idle_q;
    pulse_d     = pulse_q;
    timeout_d   = timeout_q;
    rev_d       = rev_q;
    stop_d      = stop_q;
    fwd_d       = fwd_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_ev_d    = out_ev_q;
    out_pulse_d = out_pulse_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    fetch       = 1'b0;
    emit        = 1'b0;
    ev          = EV_NONE;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDLE_TIMEOUT:  timeout_d = cfg_data_i;
        CFG_PULSE_REVERSE: rev_d     = cfg_data_i[PULSE_W-1:0];
        CFG_PULSE_STOP:    stop_d    = cfg_data_i[PULSE_W-1:0];
        CFG_PULSE_FORWARD: fwd_d     = cfg_data_i[PULSE_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            KIND_TICK: begin
              emit = 1'b1;
              if (idle_inc > timeout_q) begin
                pulse_d = stop_q;
                idle_d  = '0;
                ev      = EV_TIMEOUT;
              end else begin
                idle_d = idle_inc;
              end
            end
            KIND_CHAR: begin
              emit = 1'b1;
              if (len_q != LEN_MAX) begin
                mem_we = 1'b1;
                len_d  = len_q + 1'b1;
              end else begin
                len_d = '0;
                ev    = EV_OVERFLOW;
              end
            end
            KIND_EOL: begin
              if (len_q == '0) begin
                emit = 1'b1;
              end else begin
                state_d   = ST_SCAN;
                idx_d     = '0;
                wlen_d    = '0;
                started_d = 1'b0;
                gap_d     = 1'b0;
                bad_d     = 1'b0;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // Reads run one character ahead of the matcher.
        if (idx_q != len_q) begin
          fetch  = 1'b1;
          rvld_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
        if (rvld_q) begin
          if (rdata_q == CHAR_SPACE) begin
            if (started_q) begin
              gap_d = 1'b1;
            end
          end else if (gap_q || wlen_q == WLEN_MAX) begin
            // No command has an inner space or runs past seven letters.
            bad_d = 1'b1;
          end else begin
            word_d[wlen_q] = rdata_q;
            wlen_d         = wlen_q + 1'b1;
            started_d      = 1'b1;
          end
        end
        if (idx_q == len_q && !rvld_q && slot_free) begin
          emit    = 1'b1;
          ev      = bad_q ? EV_INVALID : match_word(word_q, wlen_q);
          len_d   = '0;
          state_d = ST_IDLE;
          case (ev)
            EV_UP:   pulse_d = fwd_q;
            EV_DOWN: pulse_d = rev_q;
            EV_STOP: pulse_d = stop_q;
            default: ;
          endcase
          if (ev != EV_INVALID) begin
            idle_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_vld_d   = 1'b1;
      out_ev_d    = ev;
      out_pulse_d = pulse_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      word_q      <= '0;
      wlen_q      <= '0;
      started_q   <= 1'b0;
      gap_q       <= 1'b0;
      bad_q       <= 1'b0;
      idle_q      <= '0;
      pulse_q     <= PULSE_STOP_RST;
      timeout_q   <= IDLE_TIMEOUT_RST;
      rev_q       <= PULSE_REVERSE_RST;
      stop_q      <= PULSE_STOP_RST;
      fwd_q       <= PULSE_FORWARD_RST;
      out_vld_q   <= 1'b0;
      out_ev_q    <= EV_NONE;
      out_pulse_q <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      rvld_q      <= rvld_d;
      word_q      <= word_d;
      wlen_q      <= wlen_d;
      started_q   <= started_d;
      gap_q       <= gap_d;
      bad_q       <= bad_d;
      idle_q      <= idle_d;
      pulse_q     <= pulse_d;
      timeout_q   <= timeout_d;
      rev_q       <= rev_d;
      stop_q      <= stop_d;
      fwd_q       <= fwd_d;
      out_vld_q   <= out_vld_d;
      out_ev_q    <= out_ev_d;
      out_pulse_q <= out_pulse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[len_q[AW-1:0]] <= q_cmd_i.chr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      rdata_q <= store_q[idx_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_vld_q;
  assign event_res_o = out_ev_q;
  assign pulse_us_o  = out_pulse_q;

endmodule

// File: rtl/core/motor_command_line_decoder.sv
// Decodes motor commands typed on a serial line and keeps the motor pulse
// width. Every transaction in (a received byte or a millisecond tick) gives
// exactly one transaction out with an event code and the pulse width after
// it. The front classifies and lower-cases each byte and accepts one
// transaction per cycle while its two-entry queue has room. The back takes
// ticks, ignored bytes and printable bytes straight from the queue head; a
// line end on a non-empty line starts a scan of the line store, which has
// one read port, and the matcher walks it one character per cycle. A finished
// result waits in the output register while the queue keeps filling. No
// clearing pass follows reset.
module motor_command_line_decoder #(
  parameter int unsigned LINE_CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [11:0] pulse_us_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import mcld_pkg::*;

  cmd_t   push_cmd;
  cmd_t   head_cmd;
  qstat_t q_stat;
  logic   push;
  logic   pop;

  mcld_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .rx_byte_i  (rx_byte_i),
    .qstat_i    (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mcld_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  mcld_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (!q_stat.empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .pulse_us_o  (pulse_us_o)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("back took a transaction from an empty queue");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped before it was taken");

endmodule

// File: sim/tb_motor_command_line_decoder.sv
`timescale 1ns / 1ps

module tb_motor_command_line_decoder;
  import mcld_pkg::*;

  localparam int unsigned LINE_CAPACITY = 16;
  localparam int unsigned LINE_MAX      = LINE_CAPACITY - 1;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned RANDOM_PHASES = 8;

  typedef struct packed {
    logic [3:0]         ev;
    logic [PULSE_W-1:0] pulse;
  } motor_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              func_i      = 1'b0;
  logic [7:0]        rx_byte_i   = 8'h00;
  logic              out_ready_i = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = CFG_IDLE_TIMEOUT;
  logic [31:0]       cfg_data_i  = 32'h0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [3:0]        event_res_o;
  logic [11:0]       pulse_us_o;

  // Register copies and decoder state mirrored by the testbench.
  logic [31:0]        timeout_ms;
  logic [PULSE_W-1:0] reverse_us;
  logic [PULSE_W-1:0] stop_us;
  logic [PULSE_W-1:0] forward_us;
  logic [7:0]         line_chars [LINE_MAX];
  logic [7:0]         folded     [LINE_MAX];
  int unsigned        line_len;
  logic [31:0]        idle_ms;
  logic [PULSE_W-1:0] drive_us;

  motor_result_t pending_results [$];
  motor_result_t head_result;

  int unsigned send_gap_max    = 16;
  int unsigned stall_max       = 16;
  int unsigned hold_off_cycles = 0;
  int unsigned items_sent      = 0;
  int unsigned config_phases   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned event_seen [16];

  string command_words [10] = '{"w", "up", "x", "down", "s", "stop", "h", "help", "p",
                                "present"};

  motor_command_line_decoder #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .event_res_o(event_res_o),
    .pulse_us_o (pulse_us_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit folded_is(int unsigned head, int unsigned len, string w);
    int unsigned k;
    if (w.len() != len) return 1'b0;
    for (k = 0; k < len; k++) begin
      if (folded[head + k] != w[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Lower-cases the stored line, trims spaces at both ends and names the command.
  function automatic event_e classify_line();
    int unsigned head;
    int unsigned tail;
    int unsigned len;
    logic [7:0]  c;
    for (int unsigned i = 0; i < line_len; i++) begin
      c = line_chars[i];
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) c = c | CASE_BIT;
      folded[i] = c;
    end
    head = 0;
    while (head < line_len && folded[head] == CHAR_SPACE) head++;
    tail = line_len;
    while (tail > head && folded[tail - 1] == CHAR_SPACE) tail--;
    len = tail - head;
    if (folded_is(head, len, "w") || folded_is(head, len, "up")) return EV_UP;
    if (folded_is(head, len, "x") || folded_is(head, len, "down")) return EV_DOWN;
    if (folded_is(head, len, "s") || folded_is(head, len, "stop")) return EV_STOP;
    if (folded_is(head, len, "h") || folded_is(head, len, "help")) return EV_HELP;
    if (folded_is(head, len, "p") || folded_is(head, len, "present")) return EV_PRESENT;
    return EV_INVALID;
  endfunction

  function automatic motor_result_t decode_item(logic f, logic [7:0] b);
    event_e        ev;
    motor_result_t r;
    ev = EV_NONE;
    if (f) begin
      if (idle_ms != 32'hFFFF_FFFF) idle_ms++;
      if (idle_ms > timeout_ms) begin
        drive_us = stop_us;
        idle_ms  = '0;
        ev       = EV_TIMEOUT;
      end
    end else if (b == CHAR_LF || b == CHAR_CR) begin
      if (line_len > 0) begin
        ev = classify_line();
        case (ev)
          EV_UP:   drive_us = forward_us;
          EV_DOWN: drive_us = reverse_us;
          EV_STOP: drive_us = stop_us;
          default: ;
        endcase
        // Help and present count as valid commands too; only junk keeps the count.
        if (ev != EV_INVALID) idle_ms = '0;
        line_len = 0;
      end
    end else if (b >= CHAR_SPACE && b <= CHAR_TILDE) begin
      if (line_len < LINE_MAX) begin
        line_chars[line_len] = b;
        line_len++;
      end else begin
        line_len = 0;
        ev       = EV_OVERFLOW;
      end
    end
    r.ev    = ev;
    r.pulse = drive_us;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input logic f, input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    rx_byte_i  <= b;
    pending_results.push_back(decode_item(f, b));
    if (f || b == CHAR_LF || b == CHAR_CR || (b >= CHAR_SPACE && b <= CHAR_TILDE)) begin
      items_sent++;
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Upper data bits of the pulse registers are random to check that they are dropped.
  task automatic set_config(input logic [31:0] t, input logic [PULSE_W-1:0] rev,
                            input logic [PULSE_W-1:0] stp, input logic [PULSE_W-1:0] fwd);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDLE_TIMEOUT;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_REVERSE;
    cfg_data_i <= {20'($urandom), rev};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_STOP;
    cfg_data_i <= {20'($urandom), stp};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_FORWARD;
    cfg_data_i <= {20'($urandom), fwd};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    timeout_ms = t;
    reverse_us = rev;
    stop_us    = stp;
    forward_us = fwd;
    config_phases++;
  endtask

  function automatic logic [PULSE_W-1:0] random_pulse();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return PULSE_W'($urandom);
    endcase
  endfunction

  // Sends a word's first keep letters in random case, with stray ticks and bytes.
  task automatic send_word(input string w, input int unsigned keep);
    logic [7:0] c;
    for (int unsigned i = 0; i < keep; i++) begin
      c = w[i];
      if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
      if ($urandom_range(0, 15) == 0) send_item(1'b1, 8'($urandom));
      if ($urandom_range(0, 23) == 0) send_item(1'b0, 8'($urandom_range(8'h80, 8'hFF)));
      send_item(1'b0, c);
    end
  endtask

  task automatic send_line_end();
    send_item(1'b0, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic send_random_burst();
    string       w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w    = command_words[$urandom_range(0, 9)];
    if (pick < 55) begin
      repeat ($urandom_range(0, 4)) send_item(1'b0, CHAR_SPACE);
      send_word(w, w.len());
      repeat ($urandom_range(0, 4)) send_item(1'b0, CHAR_SPACE);
      send_line_end();
    end else if (pick < 62) begin
      // Near misses: a command cut short or with one letter too many.
      if ($urandom_range(0, 1)) begin
        send_word(w, w.len() - 1);
      end else begin
        send_word(w, w.len());
        send_item(1'b0, 8'($urandom_range("a", "z")));
      end
      send_line_end();
    end else if (pick < 72) begin
      send_ticks($urandom_range(1, 12));
    end else if (pick < 80) begin
      repeat ($urandom_range(0, LINE_MAX - 1)) begin
        send_item(1'b0, 8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
      end
      send_line_end();
    end else if (pick < 85) begin
      repeat ($urandom_range(LINE_MAX, LINE_MAX + 3)) begin
        send_item(1'b0, 8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
      end
      if ($urandom_range(0, 1)) send_line_end();
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom));
    end else begin
      send_item(1'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_line_commands();
    send_item(1'b1, 8'hFF);
    send_text("w\015");
    send_text(" DoWn \n");
    send_text("S\015");
    send_text("h\n");
    send_text("Present\015");
    send_text("  \n");
    send_item(1'b0, CHAR_LF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'hFF);
  endtask

  task automatic test_line_overflow();
    repeat (LINE_MAX) send_item(1'b0, 8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
    send_item(1'b0, "a");
    send_text("up\015");
  endtask

  task automatic test_idle_timeout();
    set_config(32'd0, PULSE_REVERSE_RST, PULSE_STOP_RST, PULSE_FORWARD_RST);
    send_text("w\015");
    send_ticks(2);
    // The new stop width only shows up at the next timeout or stop command.
    set_config(32'd3, 12'h000, 12'hFFF, 12'h000);
    send_text("x\015");
    send_ticks(3);
    send_text("q\015");
    send_ticks(1);
    send_text("p\n");
    send_ticks(4);
    set_config(32'hFFFF_FFFF, 12'h123, 12'h456, 12'h789);
    send_text("w\015");
    send_ticks(20);
  endtask

  task automatic test_register_extremes();
    set_config(32'd50, 12'hFFF, 12'h000, 12'hFFF);
    send_text("up\015x\ns\015");
    set_config(32'd50, 12'h000, 12'hFFF, 12'h000);
    send_text("stop\nw\015down\n");
  endtask

  task automatic test_output_backpressure();
    int unsigned goal;
    set_config(32'd20, random_pulse(), random_pulse(), random_pulse());
    send_gap_max    = 0;
    stall_max       = 0;
    hold_off_cycles = 400;
    goal = items_sent + 40;
    while (items_sent < goal) send_random_burst();
    wait_drained();
    send_gap_max = 16;
    stall_max    = 16;
  endtask

  task automatic test_random_traffic();
    logic [31:0] t;
    int unsigned goal;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       t = 32'd0;
        1:       t = 32'hFFFF_FFFF;
        2:       t = $urandom;
        default: t = $urandom_range(1, 30);
      endcase
      set_config(t, random_pulse(), random_pulse(), random_pulse());
      case ($urandom_range(0, 3))
        0: begin
          send_gap_max = 0;
          stall_max    = 0;
        end
        1: begin
          send_gap_max = 0;
          stall_max    = 16;
        end
        default: begin
          send_gap_max = 16;
          stall_max    = 16;
        end
      endcase
      goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < goal) send_random_burst();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        stall = $urandom_range(0, stall_max);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: event %0d, pulse %0d", $time,
                 event_res_o, pulse_us_o);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        event_seen[head_result.ev]++;
        if (event_res_o !== head_result.ev) begin
          $display("%0t: event mismatch, expected %0d, got %0d", $time, head_result.ev,
                   event_res_o);
          mismatch_count++;
        end
        if (pulse_us_o !== head_result.pulse) begin
          $display("%0t: pulse mismatch, expected %0d, got %0d", $time, head_result.pulse,
                   pulse_us_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_limit
    #10_000_000;
    $display("%0t: run timed out with %0d results pending", $time, pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_flow
    timeout_ms = IDLE_TIMEOUT_RST;
    reverse_us = PULSE_REVERSE_RST;
    stop_us    = PULSE_STOP_RST;
    forward_us = PULSE_FORWARD_RST;
    line_len   = 0;
    idle_ms    = '0;
    drive_us   = PULSE_STOP_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_commands();
    test_line_overflow();
    test_idle_timeout();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_drained();

    $display("Checked %0d transactions over %0d register settings: %0d up, %0d down, %0d stop,",
             items_sent, config_phases, event_seen[EV_UP], event_seen[EV_DOWN],
             event_seen[EV_STOP]);
    $display("%0d help, %0d present, %0d invalid, %0d overflow, %0d idle timeouts.",
             event_seen[EV_HELP], event_seen[EV_PRESENT], event_seen[EV_INVALID],
             event_seen[EV_OVERFLOW], event_seen[EV_TIMEOUT]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mcld_pkg.sv
rtl/core/mcld_queue.sv
rtl/core/mcld_front.sv
rtl/core/mcld_back.sv
rtl/core/motor_command_line_decoder.sv
sim/tb_motor_command_line_decoder.sv
